// File: hw/rtl/assert_macros.svh
// Assertion macros used by the breathing LED core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked check, suspended while reset is held.
`define BLP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed: %m");
// Clocked check that also holds during reset.
`define BLP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed: %m");
`else
`define BLP_ASSERT(lbl, clk, rst_n, prop)
`define BLP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: hw/rtl/blp_pkg.sv
// Types and constants for the breathing LED PWM block.
package blp_pkg;

    localparam int MIN_PERIOD_W  = 16;
    localparam int STEP_W        = 13;
    localparam int MAX_PERIOD_W  = 16;
    localparam int PERIOD_OUT_W  = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_TDATA_W    = 8;
    localparam int OUT_TDATA_W   = 24;

    localparam logic [MIN_PERIOD_W-1:0] MIN_PERIOD_RST = 16'd10;
    localparam logic [STEP_W-1:0]       STEP_RST       = 13'd10;
    localparam logic [MAX_PERIOD_W-1:0] MAX_PERIOD_RST = 16'd1000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MIN_PERIOD  = 2'd0,
        CFG_PERIOD_STEP = 2'd1,
        CFG_MAX_PERIOD  = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [MIN_PERIOD_W-1:0] min_period;
        logic [STEP_W-1:0]       period_step;
        logic [MAX_PERIOD_W-1:0] max_period;
    } t_cfg;

    typedef struct packed {
        logic                    led_on;
        logic [PERIOD_OUT_W-1:0] period_now;
        logic                    period_changed;
    } t_result;

endpackage

// File: hw/rtl/blp_core.sv
// Period adjust and breathing ramp state, one tick per step.
module blp_core #(
    parameter int PERIOD_WIDTH = 16,
    parameter int START_PERIOD = 100
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  blp_pkg::t_cfg    i_cfg,
    input  logic             i_step,
    input  logic             i_up_press,
    input  logic             i_down_press,
    output blp_pkg::t_result o_result
);
    import blp_pkg::*;
    `include "assert_macros.svh"

    localparam int W  = PERIOD_WIDTH;
    localparam int SW = ((W > MAX_PERIOD_W) ? W : MAX_PERIOD_W) + 2;
    localparam logic [SW-1:0] PMASK = {{(SW-W){1'b0}}, {W{1'b1}}};
    localparam longint unsigned PMAX = (64'd1 << W) - 64'd1;
    localparam longint unsigned START_L = longint'(START_PERIOD);
    localparam logic [W-1:0] START_RST = W'((START_L > PMAX) ? PMAX : START_L);

    logic [W-1:0] r_period, n_period;
    logic [W-1:0] r_index, n_index;
    logic [W-1:0] r_ticks, n_ticks;
    logic         r_fall, n_fall;
    logic         r_off, n_off;

    logic [SW-1:0] p_ext, step_ext, min_ext, max_ext, sum, up_val, dn_val, np_ext;
    logic [W:0]    i_plus1;
    logic [W-1:0]  rest, dur;
    logic          steady, led;

    always_comb begin
        p_ext    = SW'(r_period);
        step_ext = SW'(i_cfg.period_step);
        min_ext  = SW'(i_cfg.min_period);
        max_ext  = SW'(i_cfg.max_period);

        // up saturates at the ceiling, then at the register width
        sum    = p_ext + step_ext;
        up_val = (sum > max_ext) ? max_ext : sum;
        up_val = (up_val > PMASK) ? PMASK : up_val;
        // down floors at min_period
        if (p_ext >= min_ext + step_ext) begin
            dn_val = p_ext - step_ext;
        end else begin
            dn_val = (min_ext > PMASK) ? PMASK : min_ext;
        end

        if (i_up_press) begin
            np_ext = up_val;
        end else if (i_down_press) begin
            np_ext = dn_val;
        end else begin
            np_ext = p_ext;
        end
        n_period = np_ext[W-1:0];
        steady   = (np_ext <= min_ext) || (np_ext <= SW'(1));

        n_index = r_index;
        n_ticks = r_ticks;
        n_fall  = r_fall;
        n_off   = r_off;
        i_plus1 = '0;
        rest    = '0;
        dur     = '0;
        led     = 1'b1;

        if (steady) begin
            n_index = W'(1);
            n_ticks = '0;
            n_fall  = 1'b0;
            n_off   = 1'b0;
        end else begin
            if (r_ticks == '0) begin
                // end the ramp when an on half would start at or past the period
                if (!r_off && (r_index >= n_period)) begin
                    n_index = W'(1);
                    n_fall  = ~r_fall;
                end
                i_plus1 = {1'b0, n_index} + (W+1)'(1);
                rest    = ({1'b0, n_period} > i_plus1) ? (n_period - n_index) : W'(1);
                if (n_fall) begin
                    dur = r_off ? n_index : rest;
                end else begin
                    dur = r_off ? rest : n_index;
                end
                n_ticks = dur;
            end
            led     = ~r_off;
            n_ticks = n_ticks - W'(1);
            if (n_ticks == '0) begin
                if (r_off) begin
                    n_off = 1'b0;
                    if (n_index != {W{1'b1}}) begin
                        n_index = n_index + W'(1);
                    end
                end else begin
                    n_off = 1'b1;
                end
            end
        end

        o_result.led_on         = led;
        o_result.period_now     = np_ext[PERIOD_OUT_W-1:0];
        o_result.period_changed = (n_period != r_period);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= START_RST;
            r_index  <= W'(1);
            r_ticks  <= '0;
            r_fall   <= 1'b0;
            r_off    <= 1'b0;
        end else if (i_step) begin
            r_period <= n_period;
            r_index  <= n_index;
            r_ticks  <= n_ticks;
            r_fall   <= n_fall;
            r_off    <= n_off;
        end
    end

    // ramp index starts at one and never wraps to zero
    `BLP_ASSERT(a_index_nonzero, i_clk, i_rst_n, r_index != '0)
    // a steady-on tick puts the ramp back to its start
    `BLP_ASSERT(a_steady_restart, i_clk, i_rst_n,
        i_step && steady |=> r_index == W'(1) && !r_off && !r_fall && r_ticks == '0)
    // state moves only on a tick
    `BLP_ASSERT(a_hold_idle, i_clk, i_rst_n,
        !i_step |=> $stable(r_period) && $stable(r_index) && $stable(r_ticks))

endmodule

// File: hw/rtl/breathing_led_pwm_with_period_buttons.sv
// Breathing LED PWM top level: stream ports, configuration registers, pipeline.
//
// Each input word is one millisecond tick carrying an up-press flag (bit 0)
// and a down-press flag (bit 1). The tick first adjusts the breath period:
// up has priority and adds period_step, saturating at max_period; down
// subtracts period_step, or falls back to min_period. At or below
// min_period (or at a period of one or less) the LED is steady on and the ramp
// restarts; otherwise it breathes along a rising then falling triangular
// duty ramp. One output word per input word carries the LED level, the
// period after the press and a changed flag. Rate: one word per clock
// while the output side takes each result. An input word waits in the
// input register, then moves into the result register behind the
// single-pass period and ramp logic once the output slot is free. When the
// output side holds off, both registers fill and the input stalls until
// the result word is taken.
// The user must write configuration through the cfg channel only while
// the block is idle; the block itself does not enforce it. Index 0 is
// min_period, 1 period_step, 2 max_period, other indexes are accepted and dropped.
module breathing_led_pwm_with_period_buttons #(
    parameter int PERIOD_WIDTH = 16,
    parameter int START_PERIOD = 100
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration write channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [blp_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [blp_pkg::CFG_DATA_W-1:0]      i_cfg_wdata,
    // tick input
    input  logic                                i_s_axis_tvalid,
    output logic                                o_s_axis_tready,
    // tdata: [0] up_press, [1] down_press, [7:2] zero
    input  logic [blp_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,
    // result output
    output logic                                o_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    // tdata: [0] led_on, [16:1] period_now, [17] period_changed, [23:18] zero
    output logic [blp_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata
);
    import blp_pkg::*;

    t_cfg    r_cfg;
    t_result core_res;
    t_result r_res;

    logic r_in_vld;
    logic r_up;
    logic r_dn;
    logic r_out_vld;
    logic adv;

    // configuration registers; always ready, unknown indexes dropped
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.min_period  <= MIN_PERIOD_RST;
            r_cfg.period_step <= STEP_RST;
            r_cfg.max_period  <= MAX_PERIOD_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_MIN_PERIOD:  r_cfg.min_period  <= i_cfg_wdata[MIN_PERIOD_W-1:0];
                CFG_PERIOD_STEP: r_cfg.period_step <= i_cfg_wdata[STEP_W-1:0];
                CFG_MAX_PERIOD:  r_cfg.max_period  <= i_cfg_wdata[MAX_PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // advance the input word into the result register when the output slot frees up
    assign adv             = r_in_vld && (!r_out_vld || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_vld || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_vld <= i_s_axis_tvalid;
        end
    end

    // hold the flags of the word in the input register
    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_up <= i_s_axis_tdata[0];
            r_dn <= i_s_axis_tdata[1];
        end
    end

    blp_core #(
        .PERIOD_WIDTH (PERIOD_WIDTH),
        .START_PERIOD (START_PERIOD)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_step       (adv),
        .i_up_press   (r_up),
        .i_down_press (r_dn),
        .o_result     (core_res)
    );

    // result register: load on advance, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_res <= core_res;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {6'd0, r_res.period_changed, r_res.period_now, r_res.led_on};

endmodule

// File: tb/tb_breathing_led_pwm_with_period_buttons.sv
// Self-checking testbench for the breathing LED PWM block with period buttons.
module tb_breathing_led_pwm_with_period_buttons;
    import blp_pkg::*;

    localparam int START_PERIOD  = 100;
    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int MAX_IDLE      = 18;
    localparam int LONG_HOLD     = 150;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    localparam int RANDOM_TICKS  = 115;
    localparam int PERIOD_SAT    = 65535;

    // Index 3 is not a register: the block takes the word and drops it.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    typedef enum int {
        IDLE_NONE,
        IDLE_RANDOM,
        IDLE_SPARSE
    } t_idle_mode;

    typedef struct {
        bit up;
        bit down;
        int gap;
    } t_tick;

    logic                   i_clk           = 1'b0;
    logic                   i_rst_n         = 1'b0;
    logic                   i_cfg_valid     = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index     = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_wdata     = '0;
    logic                   i_s_axis_tvalid = 1'b0;
    logic                   o_s_axis_tready;
    logic [IN_TDATA_W-1:0]  i_s_axis_tdata  = '0;  // [0] up_press, [1] down_press
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b0;
    // [0] led_on, [16:1] period_now, [17] period_changed
    logic [OUT_TDATA_W-1:0] o_m_axis_tdata;

    // Ticks waiting to be offered, and LED words waiting to come out.
    t_tick   tick_q[$];
    t_result led_expect_q[$];

    t_idle_mode tx_mode = IDLE_RANDOM;
    t_idle_mode rx_mode = IDLE_RANDOM;
    bit         hold_req  = 1'b0;
    bit         hold_done = 1'b0;

    int tx_wait;
    int rx_wait;
    int hold_left;
    int quiet_cycles = 0;
    int mismatches   = 0;
    int ticks_in     = 0;
    int words_out    = 0;
    int cfg_writes   = 0;
    int settings     = 1;

    // Predictor copy of the registers and the breathing state.
    t_cfg shadow_cfg;
    int   breath_period;
    int   ramp_pos;
    int   half_left;
    bit   on_falling;
    bit   in_off_half;

    breathing_led_pwm_with_period_buttons #(
        .PERIOD_WIDTH (16),
        .START_PERIOD (START_PERIOD)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // Draw the idle cycles that go ahead of one word.
    function automatic int idle_draw(t_idle_mode mode);
        case (mode)
            IDLE_RANDOM: return $urandom_range(0, MAX_IDLE);
            IDLE_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, MAX_IDLE) : 0;
            default:     return 0;
        endcase
    endfunction

    // Back to the start of the rising ramp, on half first.
    function automatic void restart_ramp();
        ramp_pos    = 1;
        half_left   = 0;
        on_falling  = 1'b0;
        in_off_half = 1'b0;
    endfunction

    // Apply one tick's presses and work out the LED word it yields.
    function automatic t_result breath_tick(bit up, bit down);
        t_result res;
        int      prev_period;
        int      p;
        int      sum;
        int      floor_p;
        int      step;
        int      ceil_p;
        int      rest;
        int      span;
        bit      led;

        floor_p     = shadow_cfg.min_period;
        step        = shadow_cfg.period_step;
        ceil_p      = shadow_cfg.max_period;
        prev_period = breath_period;
        p           = breath_period;

        // Up wins over down; down falls back to the floor instead of going under it.
        if (up) begin
            sum = p + step;
            p   = (sum > ceil_p) ? ceil_p : sum;
            if (p > PERIOD_SAT) p = PERIOD_SAT;
        end else if (down) begin
            if (p >= floor_p + step) p = p - step;
            else p = floor_p;
        end
        breath_period = p;

        if (p <= floor_p || p <= 1) begin
            led = 1'b1;
            restart_ramp();
        end else begin
            // A half takes its length from the period at the tick it starts.
            if (half_left == 0) begin
                if (!in_off_half && ramp_pos >= p) begin
                    ramp_pos   = 1;
                    on_falling = !on_falling;
                end
                rest = (p > ramp_pos + 1) ? p - ramp_pos : 1;
                if (on_falling) span = in_off_half ? ramp_pos : rest;
                else span = in_off_half ? rest : ramp_pos;
                half_left = (span > PERIOD_SAT) ? PERIOD_SAT : span;
            end
            led = !in_off_half;
            half_left--;
            if (half_left == 0) begin
                if (in_off_half) begin
                    in_off_half = 1'b0;
                    if (ramp_pos < PERIOD_SAT) ramp_pos++;
                end else begin
                    in_off_half = 1'b1;
                end
            end
        end

        res.led_on         = led;
        res.period_now     = p[PERIOD_OUT_W-1:0];
        res.period_changed = (p != prev_period);
        return res;
    endfunction

    function automatic void flag_error(string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endfunction

    // Offer the queued ticks, each after its own idle gap.
    always @(posedge i_clk) begin : tick_driver
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            tx_wait         <= 0;
        end else if (!i_s_axis_tvalid || o_s_axis_tready) begin
            if (tick_q.size() == 0) begin
                i_s_axis_tvalid <= 1'b0;
            end else if (tx_wait < tick_q[0].gap) begin
                i_s_axis_tvalid <= 1'b0;
                tx_wait         <= tx_wait + 1;
            end else begin
                i_s_axis_tvalid <= 1'b1;
                i_s_axis_tdata  <= {{(IN_TDATA_W-2){1'b0}}, tick_q[0].down, tick_q[0].up};
                tx_wait         <= 0;
                void'(tick_q.pop_front());
            end
        end
    end

    // Track register writes, predict every accepted tick, check every LED word
    // and pace the output side.
    always @(posedge i_clk) begin : led_monitor
        t_result got;
        t_result want;

        if (!i_rst_n) begin
            shadow_cfg.min_period  = MIN_PERIOD_RST;
            shadow_cfg.period_step = STEP_RST;
            shadow_cfg.max_period  = MAX_PERIOD_RST;
            breath_period          = START_PERIOD;
            restart_ramp();
            rx_wait                = 0;
            hold_left              = 0;
            i_m_axis_tready       <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                cfg_writes++;
                case (i_cfg_index)
                    CFG_MIN_PERIOD:  shadow_cfg.min_period  = i_cfg_wdata;
                    CFG_PERIOD_STEP: shadow_cfg.period_step = i_cfg_wdata[STEP_W-1:0];
                    CFG_MAX_PERIOD:  shadow_cfg.max_period  = i_cfg_wdata;
                    default: ;
                endcase
            end

            if (i_s_axis_tvalid && o_s_axis_tready) begin
                ticks_in++;
                led_expect_q.push_back(breath_tick(i_s_axis_tdata[0], i_s_axis_tdata[1]));
            end

            if (o_m_axis_tvalid && i_m_axis_tready) begin
                words_out++;
                got.led_on         = o_m_axis_tdata[0];
                got.period_now     = o_m_axis_tdata[PERIOD_OUT_W:1];
                got.period_changed = o_m_axis_tdata[PERIOD_OUT_W+1];
                if (led_expect_q.size() == 0) begin
                    flag_error($sformatf("%0t: word %0d came with nothing expected (led %0b period %0d changed %0b)",
                        $time, words_out, got.led_on, got.period_now, got.period_changed));
                end else begin
                    want = led_expect_q.pop_front();
                    if (got.led_on !== want.led_on || got.period_now !== want.period_now ||
                        got.period_changed !== want.period_changed) begin
                        flag_error($sformatf({"%0t: word %0d expected led %0b period %0d changed %0b,",
                            " got led %0b period %0d changed %0b"}, $time, words_out,
                            want.led_on, want.period_now, want.period_changed,
                            got.led_on, got.period_now, got.period_changed));
                    end
                end
                rx_wait = idle_draw(rx_mode);
            end else if (rx_wait > 0) begin
                rx_wait--;
            end

            // One long hold-off: the block fills and must stall its input.
            if (hold_req && !hold_done) begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end else if (hold_left > 0) begin
                hold_left--;
            end

            i_m_axis_tready <= (rx_wait == 0 && hold_left == 0);
        end
    end

    // Give up when no word moves on any channel for too long.
    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_tick(bit up, bit down);
        t_tick tk;
        tk.up   = up;
        tk.down = down;
        tk.gap  = idle_draw(tx_mode);
        tick_q.push_back(tk);
    endtask

    // Hold off until every tick is in and every LED word is out, then let the
    // pipeline settle.
    task automatic drain();
        while (tick_q.size() != 0 || i_s_axis_tvalid || led_expect_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, int val);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= CFG_DATA_W'(val);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // One register setting, then well-formed random ticks with sparse presses so
    // the ramps get deep.
    task automatic random_phase(int floor_p, int step, int ceil_p, int press_pct,
                                t_idle_mode txm, t_idle_mode rxm, bit long_stall);
        drain();
        cfg_write(CFG_MIN_PERIOD, floor_p);
        cfg_write(CFG_PERIOD_STEP, step);
        cfg_write(CFG_MAX_PERIOD, ceil_p);
        settings++;
        tx_mode  = txm;
        rx_mode  = rxm;
        hold_req = long_stall;
        // Pull the period under the new ceiling first.
        push_tick(1'b1, 1'b0);
        repeat (RANDOM_TICKS)
            push_tick($urandom_range(0, 99) < press_pct, $urandom_range(0, 99) < press_pct);
    endtask

    initial begin : stimulus
        int floor_p;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset registers: plain presses, both at once, no press.
        push_tick(1'b0, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b1);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b0);
        push_tick(1'b0, 1'b0);

        // Unused index is dropped; zero step leaves the period alone.
        drain();
        cfg_write(CFG_UNUSED_IDX, '1);
        cfg_write(CFG_PERIOD_STEP, 0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);

        // Period above a lowered ceiling: up snaps it to the ceiling.
        drain();
        cfg_write(CFG_MAX_PERIOD, 50);
        push_tick(1'b1, 1'b0);

        // Top of the period range: saturation at full width, fallback to the floor.
        drain();
        cfg_write(CFG_MIN_PERIOD, 60000);
        cfg_write(CFG_PERIOD_STEP, 4096);
        cfg_write(CFG_MAX_PERIOD, PERIOD_SAT);
        push_tick(1'b0, 1'b1);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b1, 1'b0);
        push_tick(1'b0, 1'b1);
        push_tick(1'b0, 1'b1);

        drain();
        cfg_write(CFG_MIN_PERIOD, PERIOD_SAT);
        push_tick(1'b0, 1'b1);

        drain();
        cfg_write(CFG_MAX_PERIOD, 3);
        push_tick(1'b1, 1'b0);

        // Zero floor: walk through periods 2, 1 and 0 and back up to the ceiling.
        drain();
        cfg_write(CFG_MIN_PERIOD, 0);
        cfg_write(CFG_PERIOD_STEP, 1);
        settings++;
        repeat (3) push_tick(1'b0, 1'b1);
        repeat (4) push_tick(1'b1, 1'b0);
        repeat (3) push_tick(1'b0, 1'b0);

        random_phase(2, 1, 12, 8, IDLE_RANDOM, IDLE_RANDOM, 1'b0);
        random_phase(0, 1, 6, 10, IDLE_NONE, IDLE_NONE, 1'b0);
        // Sender never idles while the output side holds off for a long stretch.
        random_phase(3, 2, 30, 4, IDLE_NONE, IDLE_SPARSE, 1'b1);
        random_phase(0, 1, 4, 15, IDLE_SPARSE, IDLE_RANDOM, 1'b0);
        random_phase(0, 4095, PERIOD_SAT, 6, IDLE_RANDOM, IDLE_SPARSE, 1'b0);
        random_phase(MIN_PERIOD_RST, STEP_RST, MAX_PERIOD_RST, 20, IDLE_SPARSE, IDLE_NONE, 1'b0);
        floor_p = $urandom_range(0, 8);
        random_phase(floor_p, $urandom_range(1, 4), $urandom_range(floor_p + 2, 40),
                     $urandom_range(3, 15), IDLE_RANDOM, IDLE_RANDOM, 1'b0);
        random_phase(1, 1, 8, 5, IDLE_SPARSE, IDLE_SPARSE, 1'b0);

        drain();

        $display("Run covered %0d tick words and %0d LED words over %0d register settings",
                 ticks_in, words_out, settings);
        $display("(%0d register writes, one long output stall, %0d mismatches)",
                 cfg_writes, mismatches);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
